>>> sv/salru_pkg.sv
package salru_pkg;

  // Widths of the configuration registers and the result fields.
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned FIELD_LIMIT = 10;
  localparam int unsigned SET_FIELD_W = 10;
  localparam int unsigned WAY_FIELD_W = 3;
  localparam int unsigned RANK_W      = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [CFG_W-1:0] IDX_WIDTH_RST   = 4'd4;
  localparam logic [CFG_W-1:0] WAYS_RST        = 4'd4;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef enum logic [1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_IDX_WIDTH   = 2'd1,
    REG_WAYS_IN_USE = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
  } meta_t;

endpackage

>>> sv/salru_if.sv
interface salru_req_if #(
  parameter int unsigned ADDR_BITS = 24
);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink (input valid, input cmd, input address, output ready);
endinterface

interface salru_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic                                allocated;
  logic                                evicted;
  logic [salru_pkg::WAY_FIELD_W-1:0]   way;
  logic [salru_pkg::SET_FIELD_W-1:0]   set_index;

  modport source (output valid, output hit, output allocated, output evicted, output way,
                  output set_index, input ready);
  modport sink (input valid, input hit, input allocated, input evicted, input way,
                input set_index, output ready);
endinterface

>>> sv/set_assoc_lru_tag_lookup_core.sv
// Tag directory of a set-associative cache with true LRU replacement. Each access beat
// (load or store plus byte address) is split into offset, set index and tag by the
// offset-width and set-index-width registers, and the first ways_in_use ways of that set
// are searched. A hit makes the way most recently used; a load miss fills the first free
// way or evicts the least recently used one; a store miss changes nothing. Every access
// is handled in turn: the set index and tag are registered, the set's row is read from
// the tag and status memories, and the ways in use are compared, the way chosen and the row
// written back once the output register is free; a new access is taken only after the
// previous one has written back, while its result may still wait in the output register.
// After reset a clearing pass writes the status memory one set per cycle, so no access
// is taken until every set has been cleared; configuration writes are taken at any time.
module set_assoc_lru_tag_lookup_core #(
  parameter int unsigned MAX_SETS  = 1024,
  parameter int unsigned MAX_WAYS  = 8,
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  salru_req_if.sink                           req_i,
  salru_rsp_if.source                         rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [salru_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [salru_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [salru_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int unsigned SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned NWAYS_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned EXT_W    = ADDR_BITS + salru_pkg::SET_FIELD_W;
  localparam int unsigned SF_W     = salru_pkg::SET_FIELD_W;
  localparam int unsigned RANK_W   = salru_pkg::RANK_W;
  localparam int unsigned CFG_W    = salru_pkg::CFG_W;
  localparam bit          SET_POW2 = (MAX_SETS & (MAX_SETS - 1)) == 0;

  // Set number modulo MAX_SETS by conditional subtraction of shifted copies of the constant.
  function automatic logic [SET_W-1:0] wrap_set(input logic [SF_W-1:0] s);
    logic [SF_W:0] r;
    r = {1'b0, s};
    if (SET_POW2) begin
      r = r & (SF_W + 1)'(MAX_SETS - 1);
    end else begin
      for (int k = SF_W - 1; k >= 0; k--) begin
        if ((MAX_SETS << k) < (1 << SF_W)) begin
          if (r >= (SF_W + 1)'(MAX_SETS << k)) begin
            r = r - (SF_W + 1)'(MAX_SETS << k);
          end
        end
      end
    end
    return r[SET_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [CFG_W-1:0] offset_bits_q, idx_width_q, ways_q;
  logic             cfg_wr;
  salru_pkg::cfg_reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = salru_pkg::cfg_reg_e'(paddr[salru_pkg::APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= salru_pkg::OFFSET_BITS_RST;
      idx_width_q   <= salru_pkg::IDX_WIDTH_RST;
      ways_q        <= salru_pkg::WAYS_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        salru_pkg::REG_OFFSET_BITS: offset_bits_q <= pwdata[CFG_W-1:0];
        salru_pkg::REG_IDX_WIDTH:   idx_width_q   <= pwdata[CFG_W-1:0];
        salru_pkg::REG_WAYS_IN_USE: ways_q        <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_sel)
      salru_pkg::REG_OFFSET_BITS: prdata = salru_pkg::APB_DATA_W'(offset_bits_q);
      salru_pkg::REG_IDX_WIDTH:   prdata = salru_pkg::APB_DATA_W'(idx_width_q);
      salru_pkg::REG_WAYS_IN_USE: prdata = salru_pkg::APB_DATA_W'(ways_q);
      default:                    prdata = '0;
    endcase
  end

  // Clamped field widths and associativity.
  logic [CFG_W-1:0]   ob, sb;
  logic [NWAYS_W-1:0] nways;

  assign ob = (offset_bits_q > CFG_W'(salru_pkg::FIELD_LIMIT)) ?
              CFG_W'(salru_pkg::FIELD_LIMIT) : offset_bits_q;
  assign sb = (idx_width_q > CFG_W'(salru_pkg::FIELD_LIMIT)) ?
              CFG_W'(salru_pkg::FIELD_LIMIT) : idx_width_q;

  always_comb begin
    if (ways_q == '0) begin
      nways = NWAYS_W'(1);
    end else if ({1'b0, ways_q} > (CFG_W + 1)'(MAX_WAYS)) begin
      nways = NWAYS_W'(MAX_WAYS);
    end else begin
      nways = NWAYS_W'(ways_q);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Address split
  // ---------------------------------------------------------------------------------------
  logic [EXT_W-1:0]     addr_ext, addr_sh, tag_sh;
  logic [SF_W-1:0]      set_mask, raw_set;
  logic [CFG_W:0]       tag_shift;
  logic [SET_W-1:0]     set_new;
  logic [ADDR_BITS-1:0] tag_new;

  assign addr_ext  = EXT_W'(req_i.address);
  assign addr_sh   = addr_ext >> ob;
  assign set_mask  = ~({SF_W{1'b1}} << sb);
  assign raw_set   = addr_sh[SF_W-1:0] & set_mask;
  assign set_new   = wrap_set(raw_set);
  assign tag_shift = {1'b0, ob} + {1'b0, sb};
  assign tag_sh    = addr_ext >> tag_shift;
  assign tag_new   = tag_sh[ADDR_BITS-1:0];

  // ---------------------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------------------
  salru_pkg::state_e state_q, state_d;
  logic [SET_W-1:0]     clr_q, clr_d;
  logic [SET_W-1:0]     set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic                 cmd_q;
  logic                 rsp_valid_q;
  logic                 out_free, rd_en, commit, clearing, accept;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      salru_pkg::ST_CLEAR: begin
        if (clr_q == SET_W'(MAX_SETS - 1)) state_d = salru_pkg::ST_IDLE;
      end
      salru_pkg::ST_IDLE: begin
        if (req_i.valid) state_d = salru_pkg::ST_READ;
      end
      salru_pkg::ST_READ: state_d = salru_pkg::ST_EVAL;
      salru_pkg::ST_EVAL: begin
        if (out_free) state_d = salru_pkg::ST_IDLE;
      end
      default: state_d = salru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    clearing    = state_q == salru_pkg::ST_CLEAR;
    req_i.ready = state_q == salru_pkg::ST_IDLE;
    rd_en       = state_q == salru_pkg::ST_READ;
    commit      = (state_q == salru_pkg::ST_EVAL) && out_free;
    accept      = req_i.ready && req_i.valid;
    clr_d       = clearing ? clr_q + SET_W'(1) : clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= salru_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_new;
      tag_q <= tag_new;
      cmd_q <= req_i.cmd;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tag and status memories, one row per set
  // ---------------------------------------------------------------------------------------
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem [MAX_SETS];
  salru_pkg::meta_t [MAX_WAYS-1:0]    meta_mem [MAX_SETS];

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_rd_q, tag_wd;
  salru_pkg::meta_t [MAX_WAYS-1:0]    meta_rd_q, meta_new, meta_wd;
  logic [SET_W-1:0]                   meta_wa;
  logic                               meta_we, tag_we;

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[set_q] <= tag_wd;
    if (rd_en) tag_rd_q <= tag_mem[set_q];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (rd_en) meta_rd_q <= meta_mem[set_q];
  end

  // ---------------------------------------------------------------------------------------
  // Way compare, replacement choice and rank update
  // ---------------------------------------------------------------------------------------
  logic [MAX_WAYS-1:0] in_use, match, free;
  logic [(1 << RANK_W)-1:0] rank_seen;
  logic [RANK_W-1:0]   max_rank;
  logic [WAY_W-1:0]    hit_way, free_way, victim, target;
  logic [RANK_W:0]     old_rank;
  logic                hit, any_free, alloc, evict, update;

  always_comb begin
    rank_seen = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = NWAYS_W'(w) < nways;
      match[w]  = in_use[w] && meta_rd_q[w].valid && (tag_rd_q[w] == tag_q);
      free[w]   = in_use[w] && !meta_rd_q[w].valid;
      if (in_use[w]) rank_seen[meta_rd_q[w].rank] = 1'b1;
    end

    max_rank = '0;
    for (int r = 0; r < (1 << RANK_W); r++) begin
      if (rank_seen[r]) max_rank = RANK_W'(r);
    end

    // Lowest way number wins in each search.
    hit_way  = '0;
    free_way = '0;
    victim   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (free[w]) free_way = WAY_W'(w);
      if (in_use[w] && (meta_rd_q[w].rank == max_rank)) victim = WAY_W'(w);
    end

    hit      = |match;
    any_free = |free;
    alloc    = !hit && (cmd_q == salru_pkg::CMD_LOAD);
    evict    = alloc && !any_free;
    update   = hit || alloc;

    if (hit) begin
      target   = hit_way;
      old_rank = {1'b0, meta_rd_q[hit_way].rank};
    end else if (any_free) begin
      // A freshly filled way counts as older than every valid way.
      target   = free_way;
      old_rank = (RANK_W + 1)'(1 << RANK_W);
    end else begin
      target   = victim;
      old_rank = {1'b0, meta_rd_q[victim].rank};
    end

    meta_new = meta_rd_q;
    tag_wd   = tag_rd_q;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (WAY_W'(v) == target) begin
        meta_new[v].valid = 1'b1;
        meta_new[v].rank  = '0;
        tag_wd[v]         = tag_q;
      end else if (in_use[v] && meta_rd_q[v].valid &&
                   ({1'b0, meta_rd_q[v].rank} < old_rank) &&
                   (meta_rd_q[v].rank != salru_pkg::RANK_MAX)) begin
        meta_new[v].rank = meta_rd_q[v].rank + RANK_W'(1);
      end
    end
  end

  always_comb begin
    meta_we = clearing || (commit && update);
    meta_wa = clearing ? clr_q : set_q;
    meta_wd = clearing ? '0 : meta_new;
    tag_we  = commit && alloc;
  end

  // ---------------------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------------------
  logic                                hit_q, alloc_q, evict_q;
  logic [salru_pkg::WAY_FIELD_W-1:0]   way_q;
  logic [SF_W-1:0]                     set_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q     <= hit;
      alloc_q   <= alloc;
      evict_q   <= evict;
      way_q     <= update ? salru_pkg::WAY_FIELD_W'(target) : '0;
      set_out_q <= SF_W'(set_q);
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.hit       = hit_q;
  assign rsp_o.allocated = alloc_q;
  assign rsp_o.evicted   = evict_q;
  assign rsp_o.way       = way_q;
  assign rsp_o.set_index = set_out_q;

endmodule

>>> sv/salru_checker.sv
module salru_checker #(
  parameter int unsigned MAX_SETS = 1024
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic                              hit,
  input logic                              allocated,
  input logic                              evicted,
  input logic [salru_pkg::WAY_FIELD_W-1:0] way,
  input logic [salru_pkg::SET_FIELD_W-1:0] set_index
);

  // Only one access is in flight, so the request side is closed in the cycle after a beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an access was in flight");

  // An eviction is a kind of fill, and a fill only follows a miss.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !(allocated && hit) && (!evicted || allocated))
    else $error("inconsistent hit, fill and eviction flags");

  // A store miss names no way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !hit && !allocated |-> way == '0)
    else $error("way given for an access that neither hit nor filled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> set_index < MAX_SETS)
    else $error("set index beyond the sets built");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable({hit, allocated, evicted, way, set_index}))
    else $error("result beat changed while stalled");

endmodule

bind set_assoc_lru_tag_lookup_core salru_checker #(
  .MAX_SETS (MAX_SETS)
) u_salru_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req_i.valid),
  .req_ready (req_i.ready),
  .rsp_valid (rsp_o.valid),
  .rsp_ready (rsp_o.ready),
  .hit       (rsp_o.hit),
  .allocated (rsp_o.allocated),
  .evicted   (rsp_o.evicted),
  .way       (rsp_o.way),
  .set_index (rsp_o.set_index)
);

>>> test/set_assoc_lru_tag_lookup_core_tb.sv
`timescale 1ns / 100ps

module set_assoc_lru_tag_lookup_core_tb;

  localparam int unsigned MAX_SETS     = 1024;
  localparam int unsigned MAX_WAYS     = 8;
  localparam int unsigned ADDR_BITS    = 24;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                              hit;
    logic                              allocated;
    logic                              evicted;
    logic [salru_pkg::WAY_FIELD_W-1:0] way;
    logic [salru_pkg::SET_FIELD_W-1:0] set_index;
  } lookup_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [salru_pkg::APB_ADDR_W-1:0] paddr;
  logic [salru_pkg::APB_DATA_W-1:0] pwdata;
  logic [salru_pkg::APB_DATA_W-1:0] prdata;
  logic                             pready;

  salru_req_if #(.ADDR_BITS(ADDR_BITS)) req_bus ();
  salru_rsp_if                          rsp_bus ();

  set_assoc_lru_tag_lookup_core #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS),
    .ADDR_BITS(ADDR_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the directory and its registers.
  bit [salru_pkg::CFG_W-1:0]  cfg_offset = salru_pkg::OFFSET_BITS_RST;
  bit [salru_pkg::CFG_W-1:0]  cfg_sets   = salru_pkg::IDX_WIDTH_RST;
  bit [salru_pkg::CFG_W-1:0]  cfg_ways   = salru_pkg::WAYS_RST;
  bit [ADDR_BITS-1:0]         dir_tag   [MAX_SETS][MAX_WAYS];
  bit                         dir_valid [MAX_SETS][MAX_WAYS];
  bit [salru_pkg::RANK_W-1:0] dir_rank  [MAX_SETS][MAX_WAYS];

  lookup_result_t pending_lookups[$];
  int unsigned    mismatch_count = 0;
  int unsigned    send_gap_pct   = 0;
  int unsigned    rsp_stall_pct  = 0;
  int unsigned    tag_base       = 0;

  function automatic int unsigned eff_width(bit [salru_pkg::CFG_W-1:0] v);
    return (v > salru_pkg::FIELD_LIMIT) ? salru_pkg::FIELD_LIMIT : v;
  endfunction

  function automatic int unsigned eff_ways();
    if (cfg_ways == 0) return 1;
    if (cfg_ways > MAX_WAYS) return MAX_WAYS;
    return cfg_ways;
  endfunction

  function automatic logic [ADDR_BITS-1:0] make_addr(int unsigned tag, int unsigned set_idx,
                                                      int unsigned offs);
    int unsigned ob;
    int unsigned sb;
    logic [63:0] a;
    ob = eff_width(cfg_offset);
    sb = eff_width(cfg_sets);
    a = (64'(tag) << (ob + sb)) | ((64'(set_idx) & ((64'd1 << sb) - 1)) << ob)
        | (64'(offs) & ((64'd1 << ob) - 1));
    return a[ADDR_BITS-1:0];
  endfunction

  // A freshly filled way passes an old rank of MAX_WAYS, so it counts as older than all.
  function automatic void touch_way(int unsigned s, int unsigned w, int unsigned old_rank,
                                    int unsigned nw);
    for (int unsigned v = 0; v < nw; v++) begin
      if (v != w && dir_valid[s][v] && dir_rank[s][v] < old_rank &&
          dir_rank[s][v] < salru_pkg::RANK_MAX)
        dir_rank[s][v]++;
    end
    dir_rank[s][w] = '0;
  endfunction

  function automatic lookup_result_t predict_lookup(logic cmd, logic [ADDR_BITS-1:0] addr);
    int unsigned    ob;
    int unsigned    sb;
    int unsigned    nw;
    int unsigned    s;
    int unsigned    victim;
    bit             found;
    logic [31:0]    a;
    bit [ADDR_BITS-1:0] tag;
    lookup_result_t r;
    ob = eff_width(cfg_offset);
    sb = eff_width(cfg_sets);
    nw = eff_ways();
    a = 32'(addr);
    s = ((a >> ob) & ((32'd1 << sb) - 1)) % MAX_SETS;
    tag = ADDR_BITS'(a >> (ob + sb));
    r = '0;
    r.set_index = salru_pkg::SET_FIELD_W'(s);
    for (int unsigned w = 0; w < nw; w++) begin
      if (dir_valid[s][w] && dir_tag[s][w] == tag) begin
        r.hit = 1'b1;
        r.way = salru_pkg::WAY_FIELD_W'(w);
        touch_way(s, w, dir_rank[s][w], nw);
        break;
      end
    end
    if (!r.hit && cmd == salru_pkg::CMD_LOAD) begin
      r.allocated = 1'b1;
      found = 1'b0;
      for (int unsigned w = 0; w < nw; w++) begin
        if (!dir_valid[s][w]) begin
          found = 1'b1;
          victim = w;
          break;
        end
      end
      if (found) begin
        dir_tag[s][victim] = tag;
        dir_valid[s][victim] = 1'b1;
        touch_way(s, victim, MAX_WAYS, nw);
      end else begin
        victim = 0;
        for (int unsigned w = 1; w < nw; w++) begin
          if (dir_rank[s][w] > dir_rank[s][victim]) victim = w;
        end
        r.evicted = 1'b1;
        dir_tag[s][victim] = tag;
        touch_way(s, victim, dir_rank[s][victim], nw);
      end
      r.way = salru_pkg::WAY_FIELD_W'(victim);
    end
    return r;
  endfunction

  // Result side: random back-pressure and comparison of every beat.
  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  always @(posedge clk_i) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got = '{rsp_bus.hit, rsp_bus.allocated, rsp_bus.evicted, rsp_bus.way,
              rsp_bus.set_index};
      if (pending_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result beat with nothing expected", $realtime);
          $display("  got      hit=%0b alloc=%0b evict=%0b way=%0d set=%0d",
                   got.hit, got.allocated, got.evicted, got.way, got.set_index);
        end
      end else begin
        want = pending_lookups.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: lookup mismatch", $realtime);
            $display("  expected hit=%0b alloc=%0b evict=%0b way=%0d set=%0d",
                     want.hit, want.allocated, want.evicted, want.way, want.set_index);
            $display("  got      hit=%0b alloc=%0b evict=%0b way=%0d set=%0d",
                     got.hit, got.allocated, got.evicted, got.way, got.set_index);
          end
        end
      end
    end
  end

  task automatic send_access(logic cmd, logic [ADDR_BITS-1:0] addr);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_gap_pct) gap++;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.cmd     <= cmd;
    req_bus.address <= addr;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_lookups.push_back(predict_lookup(cmd, addr));
  endtask

  task automatic drain_lookups();
    req_bus.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(salru_pkg::cfg_reg_e idx, bit [salru_pkg::CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= salru_pkg::APB_ADDR_W'({idx, 2'b00});
    pwdata  <= {28'($urandom_range(0, 32'h0FFF_FFFF)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      salru_pkg::REG_OFFSET_BITS: cfg_offset = val;
      salru_pkg::REG_IDX_WIDTH:   cfg_sets   = val;
      salru_pkg::REG_WAYS_IN_USE: cfg_ways   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(bit [salru_pkg::CFG_W-1:0] ob, bit [salru_pkg::CFG_W-1:0] sb,
                           bit [salru_pkg::CFG_W-1:0] nw);
    drain_lookups();
    apb_write(salru_pkg::REG_OFFSET_BITS, ob);
    apb_write(salru_pkg::REG_IDX_WIDTH, sb);
    apb_write(salru_pkg::REG_WAYS_IN_USE, nw);
  endtask

  // Reset settings: hits, fills into free ways, LRU eviction and a store miss.
  task automatic test_basic_lookup();
    send_access(salru_pkg::CMD_LOAD, make_addr(0, 0, 0));
    send_access(salru_pkg::CMD_LOAD, make_addr(0, 0, 63));
    send_access(salru_pkg::CMD_STORE, 24'hFF_FFFF);
    send_access(salru_pkg::CMD_LOAD, 24'hFF_FFFF);
    send_access(salru_pkg::CMD_STORE, 24'hFF_FFFF);
    for (int unsigned t = 1; t <= 4; t++) send_access(salru_pkg::CMD_LOAD, make_addr(t, 0, 0));
    send_access(salru_pkg::CMD_LOAD, make_addr(2, 0, 5));
    send_access(salru_pkg::CMD_LOAD, make_addr(5, 0, 0));
  endtask

  // Widths above the limit saturate and zero ways act as a direct-mapped cache.
  task automatic test_field_saturation();
    configure(4'd15, 4'd15, 4'd0);
    send_access(salru_pkg::CMD_LOAD, 24'h00_0000);
    send_access(salru_pkg::CMD_LOAD, 24'h10_0000);
    send_access(salru_pkg::CMD_LOAD, 24'h0F_FFFF);
    send_access(salru_pkg::CMD_STORE, 24'h10_0000);
  endtask

  // Ways taken out of use keep their lines and ranks and are found again later.
  task automatic test_way_resizing();
    configure(4'd0, 4'd0, 4'd15);
    for (int unsigned t = 0; t < MAX_WAYS; t++)
      send_access(salru_pkg::CMD_LOAD, make_addr(t, 0, 0));
    configure(4'd0, 4'd0, 4'd2);
    send_access(salru_pkg::CMD_LOAD, make_addr(0, 0, 0));
    send_access(salru_pkg::CMD_LOAD, make_addr(9, 0, 0));
    configure(4'd0, 4'd0, 4'd8);
    send_access(salru_pkg::CMD_LOAD, make_addr(5, 0, 0));
  endtask

  // Mostly a small pool of tags over a few sets so that hits and evictions are common.
  task automatic random_access();
    int unsigned nw;
    nw = eff_ways();
    if ($urandom_range(0, 9) == 0) begin
      send_access(logic'($urandom_range(0, 1)), ADDR_BITS'($urandom));
    end else begin
      send_access(($urandom_range(0, 9) < 3) ? salru_pkg::CMD_STORE : salru_pkg::CMD_LOAD,
                  make_addr(tag_base + $urandom_range(0, nw + 1), $urandom_range(0, 3),
                            $urandom));
    end
  endtask

  task automatic test_random_traffic();
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_gap_pct = 47; rsp_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  rsp_stall_pct = 47; end
        default: begin send_gap_pct = 37; rsp_stall_pct = 37; end
      endcase
      for (int unsigned seg = 0; seg < 3; seg++) begin
        configure(salru_pkg::CFG_W'($urandom_range(0, 15)),
                  salru_pkg::CFG_W'($urandom_range(0, 15)),
                  salru_pkg::CFG_W'($urandom_range(0, 15)));
        tag_base = $urandom;
        repeat (100) random_access();
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    req_bus.valid   = 1'b0;
    req_bus.cmd     = salru_pkg::CMD_LOAD;
    req_bus.address = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_lookup();
    test_field_saturation();
    test_way_resizing();
    test_random_traffic();
    drain_lookups();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> set_assoc_lru_tag_lookup_core.f
sv/salru_pkg.sv
sv/salru_if.sv
sv/set_assoc_lru_tag_lookup_core.sv
sv/salru_checker.sv
test/set_assoc_lru_tag_lookup_core_tb.sv
